// ----- rtl/mfcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfcp_pkg
// Shared types and constants for the MSB-first code packer.
// ----------------------------------------------------------------------------
package mfcp_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int WIDTH_W   = 5;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    // byte count per word, 0..4 (enough for the largest width limit)
    localparam int NBYTE_W   = 3;

    // command codes carried on tuser
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // control that goes with a burst of packed bytes
    typedef struct packed {
        logic [NBYTE_W-1:0] nbytes;
        logic               last;
    } mfcp_burst_t;

endpackage

// ----- rtl/mfcp_pack.sv -----
// ----------------------------------------------------------------------------
// mfcp_pack
// Combinational packing step: merges a code into the pending bits and
// splits out every completed byte, or drains the pending bits on flush.
// ----------------------------------------------------------------------------
module mfcp_pack
    import mfcp_pkg::*;
#(
    parameter int MAX_CODE_WIDTH = 16
)
(
    input  logic                        cmd,
    input  logic [VALUE_W-1:0]          code_value,
    input  logic [WIDTH_W-1:0]          code_width,
    input  logic [PEND_W-1:0]           pend_bits,
    input  logic [PCNT_W-1:0]           pend_count,
    output logic [((PEND_W + MAX_CODE_WIDTH) / BYTE_W)-1:0][BYTE_W-1:0] byte_vec,
    output mfcp_burst_t                 burst,
    output logic [PEND_W-1:0]           pend_bits_next,
    output logic [PCNT_W-1:0]           pend_count_next
);

    localparam int ACC_W = PEND_W + MAX_CODE_WIDTH;
    localparam int NB    = ACC_W / BYTE_W;
    localparam int WW    = $clog2(MAX_CODE_WIDTH + 1);
    localparam int CW    = $clog2(ACC_W + 1);

    logic [WIDTH_W:0]       width_ext;
    logic [WW-1:0]          width_sat;
    logic [ACC_W+VALUE_W-1:0] value_wide;
    logic [ACC_W-1:0]       value_ext;
    logic [ACC_W-1:0]       value_mask;
    logic [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]       aligned;
    logic [CW-1:0]          count;
    logic [BYTE_W-1:0]      flush_byte;

    always_comb
    begin
        // saturate width to the limit
        width_ext = {1'b0, code_width};
        if (width_ext > (WIDTH_W+1)'(MAX_CODE_WIDTH))
            width_sat = WW'(MAX_CODE_WIDTH);
        else
            width_sat = WW'(width_ext);

        value_wide = {{ACC_W{1'b0}}, code_value};
        value_ext  = value_wide[ACC_W-1:0];
        value_mask = ~({ACC_W{1'b1}} << width_sat);

        acc     = (ACC_W'(pend_bits) << width_sat) | (value_ext & value_mask);
        count   = CW'(pend_count) + CW'(width_sat);
        // earliest bit to the top of the word
        aligned = acc << (CW'(ACC_W) - count);

        flush_byte = BYTE_W'({pend_bits, 1'b0} << (PCNT_W'(PEND_W) - pend_count));

        for (int i = 0; i < NB; i++)
            byte_vec[i] = aligned[ACC_W-1-BYTE_W*i -: BYTE_W];

        if (cmd == CMD_FLUSH)
        begin
            byte_vec[0]     = flush_byte;
            burst.nbytes    = (pend_count != '0) ? NBYTE_W'(1) : '0;
            burst.last      = 1'b1;
            pend_bits_next  = '0;
            pend_count_next = '0;
        end
        else
        begin
            burst.nbytes    = NBYTE_W'(count >> 3);
            burst.last      = 1'b0;
            pend_count_next = count[PCNT_W-1:0];
            pend_bits_next  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << count[PCNT_W-1:0]);
        end
    end

endmodule

// ----- rtl/mfcp_out_buf.sv -----
// ----------------------------------------------------------------------------
// mfcp_out_buf
// Result register: holds one burst of bytes and shifts them out one byte
// per cycle on the byte stream while the receiver is ready.
// ----------------------------------------------------------------------------
module mfcp_out_buf
    import mfcp_pkg::*;
#(
    parameter int NB = 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [NB-1:0][BYTE_W-1:0]    load_bytes,
    input  mfcp_burst_t                  load_burst,
    output logic                         can_load,
    output logic [NBYTE_W-1:0]           remaining,
    output logic                         tvalid,
    input  logic                         tready,
    output logic [BYTE_W-1:0]            tdata,
    output logic                         tlast
);

    logic [NB-1:0][BYTE_W-1:0] bytes_reg;
    logic [NBYTE_W-1:0]        rem_reg;
    logic                      last_reg;
    logic                      pop;

    assign tvalid    = (rem_reg != '0);
    assign pop       = tvalid && tready;
    assign tdata     = bytes_reg[0];
    assign tlast     = last_reg && (rem_reg == NBYTE_W'(1));
    assign can_load  = (rem_reg == '0) || (rem_reg == NBYTE_W'(1) && tready);
    assign remaining = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            last_reg <= 1'b0;
        end
        else if (load)
        begin
            rem_reg  <= load_burst.nbytes;
            last_reg <= load_burst.last;
        end
        else if (pop)
        begin
            rem_reg  <= rem_reg - NBYTE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bytes_reg <= load_bytes;
        else if (pop)
        begin
            for (int i = 0; i < NB - 1; i++)
                bytes_reg[i] <= bytes_reg[i+1];
        end
    end

endmodule

// ----- rtl/msb_first_code_packer_core.sv -----
// ----------------------------------------------------------------------------
// msb_first_code_packer_core
// Packs variable-width codes into a byte stream, most significant bit first.
// ----------------------------------------------------------------------------
// Each append word adds the low code_width bits of code_value (width capped
// at MAX_CODE_WIDTH) behind the bits already pending; every byte that fills
// up leaves on the output stream with the earliest bit in bit 7. A flush word
// (tuser = 1) sends the pending partial byte, zero-padded in its low bits,
// with tlast set, and empties the packer; a flush with nothing pending sends
// nothing. Timing: a word is held in the input register, then the
// packing logic loads its bytes into the result register. The result
// register sends one byte per cycle while the receiver is ready, so words
// with zero or one byte go at one per cycle while it is ready, and a word
// completing two bytes (up to four at the widest limit) holds the result
// register until they have left. The byte output port rate sets the
// throughput. A word reaches the output via the input and result registers.
// ----------------------------------------------------------------------------
module msb_first_code_packer_core
    import mfcp_pkg::*;
#(
    parameter int MAX_CODE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [15:0] code_value, [20:16] code_width, [23:21] zero
    input  logic        s_axis_tuser,  // [0] command: 0 append, 1 flush
    // output bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast   // last_byte
);

    localparam int ACC_W = PEND_W + MAX_CODE_WIDTH;
    localparam int NB    = ACC_W / BYTE_W;

    // input register
    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [WIDTH_W-1:0]    width_reg;

    // packer state
    logic [PEND_W-1:0]     pend_bits_reg;
    logic [PCNT_W-1:0]     pend_count_reg;
    logic [PEND_W-1:0]     pend_bits_next;
    logic [PCNT_W-1:0]     pend_count_next;

    logic [NB-1:0][BYTE_W-1:0] byte_vec;
    mfcp_burst_t           burst;
    logic                  can_load;
    logic                  fire;
    logic [NBYTE_W-1:0]    remaining;

    // a held word moves into the result register once that is free
    assign fire          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (fire)
            begin
                pend_bits_reg  <= pend_bits_next;
                pend_count_reg <= pend_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg   <= s_axis_tuser;
            value_reg <= s_axis_tdata[VALUE_W-1:0];
            width_reg <= s_axis_tdata[VALUE_W+WIDTH_W-1:VALUE_W];
        end
    end

    mfcp_pack #(
        .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
    ) u_pack (
        .cmd             (cmd_reg),
        .code_value      (value_reg),
        .code_width      (width_reg),
        .pend_bits       (pend_bits_reg),
        .pend_count      (pend_count_reg),
        .byte_vec        (byte_vec),
        .burst           (burst),
        .pend_bits_next  (pend_bits_next),
        .pend_count_next (pend_count_next)
    );

    mfcp_out_buf #(
        .NB (NB)
    ) u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_bytes (byte_vec),
        .load_burst (burst),
        .can_load   (can_load),
        .remaining  (remaining),
        .tvalid     (m_axis_tvalid),
        .tready     (m_axis_tready),
        .tdata      (m_axis_tdata),
        .tlast      (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // result register never holds more bytes than one word can make
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remaining <= NBYTE_W'(NB))
        else $error("result register over-filled");

    // a held input word is not dropped before it is packed
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("input word lost");

    // a packed flush leaves nothing pending
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd_reg == CMD_FLUSH |=> pend_count_reg == '0 && pend_bits_reg == '0)
        else $error("flush left pending bits");

    // tlast only on the final byte of a burst
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tlast |-> m_axis_tvalid && remaining == NBYTE_W'(1))
        else $error("tlast on a non-final byte");
`endif

endmodule

// ----- sim/mfcp_packer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfcp_packer_checker
// Watches both streams of the code packer, predicts the bytes, compares them.
// ----------------------------------------------------------------------------
module mfcp_packer_checker
    import mfcp_pkg::*;
#(
    parameter int MAX_CODE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          bytes_checked,
    output int          flush_bytes
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    packed_byte_t      expected_bytes[$];
    logic [PEND_W-1:0] held_bits  = '0;
    logic [PCNT_W-1:0] held_count = '0;
    int                fails      = 0;
    int                checked    = 0;
    int                flushed    = 0;

    assign fail_count    = fails;
    assign outstanding   = expected_bytes.size();
    assign bytes_checked = checked;
    assign flush_bytes   = flushed;

    // advance the packer model by one word, queueing every byte it completes
    task automatic pack_word(input logic cmd, input logic [VALUE_W-1:0] value,
                             input logic [WIDTH_W-1:0] width);
        logic [63:0]       acc;
        logic [BYTE_W-1:0] partial;
        int                count;
        int                w;
        if (cmd == CMD_FLUSH) begin
            if (held_count != 0) begin
                partial = {1'b0, held_bits};
                partial = partial << (BYTE_W - held_count);
                expected_bytes.push_back('{data: partial, last: 1'b1});
            end
            held_bits  = '0;
            held_count = '0;
        end else begin
            w = (width > MAX_CODE_WIDTH) ? MAX_CODE_WIDTH : width;
            if (w != 0) begin
                acc   = (64'(held_bits) << w) | (64'(value) & ((64'd1 << w) - 64'd1));
                count = held_count + w;
                while (count >= BYTE_W) begin
                    expected_bytes.push_back('{data: BYTE_W'(acc >> (count - BYTE_W)),
                                               last: 1'b0});
                    count -= BYTE_W;
                end
                held_count = PCNT_W'(count);
                held_bits  = PEND_W'(acc & ((64'd1 << count) - 64'd1));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        if (!rst_n) begin
            held_bits  = '0;
            held_count = '0;
            expected_bytes.delete();
        end else begin
            // compare before predicting: a word never yields a byte on its own edge
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte %02h (last %0b)", m_tdata, m_tlast);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    checked++;
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_byte: expected %0b, actual %0b", want.last, m_tlast);
                        fails++;
                    end
                    if (want.last)
                        flushed++;
                end
            end
            if (s_tvalid && s_tready)
                pack_word(s_tuser, s_tdata[15:0], s_tdata[20:16]);
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the MSB-first code packer.
// ----------------------------------------------------------------------------
// A directed run covers full and zero widths, widths past the limit, masked
// upper code bits, flushes with and without pending bits and byte-aligned
// boundaries. Random words follow in four handshake phases: free running,
// sender mostly idle, receiver mostly stalled, and light idling on both.
// The checker instance predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_top;
    import mfcp_pkg::*;

    localparam int RANDOM_WORDS = 150;   // per phase, four phases

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // [15:0] code_value, [20:16] code_width, [23:21] zero
    logic        s_axis_tuser  = CMD_APPEND; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] out_byte
    logic        m_axis_tlast;           // last_byte

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int directed_words = 0;
    int fail_count;
    int outstanding;
    int bytes_checked;
    int flush_bytes;

    always #5 clk = ~clk;

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    msb_first_code_packer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mfcp_packer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tuser       (s_axis_tuser),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tlast       (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .bytes_checked (bytes_checked),
        .flush_bytes   (flush_bytes)
    );

    // present one word, with random idle cycles ahead of it; returns on the
    // rising edge that accepts it
    task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] value,
                             input logic [WIDTH_W-1:0] width);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, width, value};
        // tready is settled by the falling edge; inputs only move on rising edges
        do begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
        words_sent++;
    endtask

    // mostly in-range appends, some zero or oversized widths, some flushes
    task automatic send_random_word();
        int pick;
        int w;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_word(CMD_FLUSH, 16'($urandom), 5'($urandom));
        end else begin
            pick = $urandom_range(99);
            if (pick < 8)
                w = 0;
            else if (pick < 15)
                w = $urandom_range(31, 17);
            else
                w = $urandom_range(16, 1);
            send_word(CMD_APPEND, 16'($urandom), 5'(w));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        send_word(CMD_FLUSH,  16'hFFFF, 5'd31);  // flush with nothing pending
        send_word(CMD_APPEND, 16'hFFFF, 5'd16);
        send_word(CMD_APPEND, 16'h0000, 5'd16);
        send_word(CMD_APPEND, 16'h0001, 5'd1);
        send_word(CMD_FLUSH,  16'h0000, 5'd0);   // single bit padded out
        send_word(CMD_APPEND, 16'hFFFF, 5'd0);   // zero width adds nothing
        send_word(CMD_APPEND, 16'hFFFE, 5'd3);   // upper bits masked off
        send_word(CMD_APPEND, 16'hAAAA, 5'd31);  // width past the limit
        send_word(CMD_APPEND, 16'h5555, 5'd17);
        send_word(CMD_APPEND, 16'h1234, 5'd7);
        send_word(CMD_APPEND, 16'h00FF, 5'd9);
        send_word(CMD_FLUSH,  16'h5A5A, 5'd21);  // code fields ignored on flush
        send_word(CMD_FLUSH,  16'h0000, 5'd0);
        send_word(CMD_APPEND, 16'h0007, 5'd3);
        send_word(CMD_APPEND, 16'hFF1F, 5'd5);   // lands on a byte boundary
        send_word(CMD_FLUSH,  16'h0000, 5'd0);   // so nothing to flush
        send_word(CMD_APPEND, 16'hFFFF, 5'd15);  // seven bits left over
        send_word(CMD_FLUSH,  16'h0000, 5'd0);
        send_word(CMD_APPEND, 16'h0003, 5'd2);
        send_word(CMD_APPEND, 16'hABCD, 5'd13);
        send_word(CMD_APPEND, 16'h8000, 5'd16);
        send_word(CMD_FLUSH,  16'hFFFF, 5'd16);
        directed_words = words_sent;

        // random phases: free run, idle sender, stalling receiver, light both
        send_idle_pct = 0;  recv_stall_pct = 0;
        repeat (RANDOM_WORDS) send_random_word();
        send_idle_pct = 69; recv_stall_pct = 0;
        repeat (RANDOM_WORDS) send_random_word();
        send_idle_pct = 0;  recv_stall_pct = 69;
        repeat (RANDOM_WORDS) send_random_word();
        send_idle_pct = 8;  recv_stall_pct = 8;
        repeat (RANDOM_WORDS) send_random_word();
        send_word(CMD_FLUSH, 16'h0000, 5'd0);

        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        // catch any stray byte behind the last expected one
        repeat (8) @(posedge clk);

        $display("Sent %0d words (%0d directed) across four idle/stall phases.",
                 words_sent, directed_words);
        $display("Checked %0d packed bytes, %0d of them flush-terminated.",
                 bytes_checked, flush_bytes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d bytes still expected", outstanding);
        $display("Some tests failed");
        $finish;
    end

endmodule
